// ===== hw/rtl/ecg_frame_parser_12bit_unpack_defines.svh =====
// Assertion helpers for the frame parser.
`ifndef ECG_FRAME_PARSER_12BIT_UNPACK_DEFINES_SVH
`define ECG_FRAME_PARSER_12BIT_UNPACK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efp assertion failed");

// Next-cycle implication, checked outside reset.
`define EFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efp assertion failed");

`endif

// ===== hw/rtl/efp_pkg.sv =====
`timescale 1ns / 1ps

package efp_pkg;

    localparam int          MAX_PAIRS_DEFAULT = 32;
    localparam logic [7:0]  FRAME_TYPE_RESET  = 8'd128;
    localparam logic [7:0]  CH_UPPER_M        = 8'h4D;
    localparam logic [7:0]  CH_A              = 8'h41;
    localparam logic [7:0]  CH_LOWER_M        = 8'h6D;
    localparam logic [8:0]  POS_LENGTH        = 9'd3;
    localparam logic [8:0]  POS_TYPE          = 9'd5;
    localparam logic [8:0]  POS_COUNT         = 9'd7;
    localparam logic [8:0]  PAYLOAD_START     = 9'd13;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_START,
        ST_LOAD,
        ST_READ
    } efp_state_t;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_MID,
        PH_LOW
    } efp_phase_t;

    typedef struct packed {
        logic take;
        logic rd_first;
        logic rd_next;
        logic load;
    } efp_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic empty;
        logic rd_last;
        logic out_free;
    } efp_stat_t;

endpackage

// ===== hw/rtl/efp_ram.sv =====
`timescale 1ns / 1ps

module efp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/efp_datapath.sv =====
`timescale 1ns / 1ps

module efp_datapath #(
    parameter int MAX_PAIRS = efp_pkg::MAX_PAIRS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic [7:0]        in_byte,
    input  efp_pkg::efp_cmd_t cmd,
    output efp_pkg::efp_stat_t stat,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [11:0]       first_sample,
    output logic [11:0]       second_sample,
    output logic              pair_valid,
    output logic              frame_last
);

    import efp_pkg::*;

    localparam int         PW      = $clog2(MAX_PAIRS + 1);
    localparam int         AW      = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [7:0] MAX_CNT = 8'(MAX_PAIRS);

    logic [7:0]    frame_type_reg, frame_type_next;
    logic [8:0]    pos_reg, pos_next;
    logic [7:0]    len_reg, len_next;
    logic [PW-1:0] target_reg, target_next;
    logic [15:0]   asm_reg, asm_next;
    efp_phase_t    phase_reg, phase_next;
    logic [PW-1:0] grp_reg, grp_next;
    logic [PW-1:0] stored_reg, stored_next;
    logic          tok_reg, tok_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [11:0]   first_reg, first_next;
    logic [11:0]   second_reg, second_next;
    logic          pv_reg, pv_next;
    logic          last_reg, last_next;

    logic [7:0]    len_eff;
    logic          tok_eff;
    logic [PW-1:0] target_eff;
    logic [PW-1:0] grp_eff;
    logic [PW-1:0] stored_eff;
    logic [15:0]   asm_eff;
    efp_phase_t    phase_eff;
    logic [8:0]    trail_pos;
    logic          at_trail;
    logic [7:0]    pairs_in;
    logic          fail;
    logic [PW-1:0] target_new;
    logic          tok_new;
    logic [8:0]    pay_pos;
    logic [8:0]    last_pos;
    logic          done;
    logic [7:0]    restart_pos;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [23:0]   ram_rdata;
    logic [PW-1:0] idx_inc;

    // Per-byte frame checks
    always_comb
    begin
        len_eff    = (pos_reg == POS_LENGTH) ? in_byte : len_reg;
        tok_eff    = (pos_reg == POS_LENGTH) ? 1'b0 : tok_reg;
        target_eff = (pos_reg == POS_LENGTH) ? '0 : target_reg;
        grp_eff    = (pos_reg == POS_LENGTH) ? '0 : grp_reg;
        stored_eff = (pos_reg == POS_LENGTH) ? '0 : stored_reg;
        asm_eff    = (pos_reg == POS_LENGTH) ? 16'h0000 : asm_reg;
        phase_eff  = (pos_reg == POS_LENGTH) ? PH_HIGH : phase_reg;
        trail_pos  = 9'(len_eff) + 9'd5;
        at_trail   = (pos_reg == trail_pos);
        pairs_in   = 8'((9'(in_byte) + 9'd1) >> 1);
        fail       = ((pos_reg == POS_TYPE) && (in_byte != frame_type_reg))
                   || (at_trail && (in_byte != CH_LOWER_M))
                   || ((pos_reg == POS_COUNT) && (pairs_in > MAX_CNT));
        target_new = (pos_reg == POS_COUNT) ? pairs_in[PW-1:0] : target_eff;
        tok_new    = tok_eff | at_trail;
        pay_pos    = (target_new != '0)
                   ? (9'd12 + 9'(target_new) + 9'({target_new, 1'b0})) : 9'd7;
        last_pos   = (trail_pos > pay_pos) ? trail_pos : pay_pos;
        done       = (pos_reg >= POS_COUNT) && !fail && (pos_reg == last_pos) && tok_new;
        restart_pos = (in_byte == CH_UPPER_M) ? 8'd1 : 8'd0;
    end

    // Byte state update
    always_comb
    begin
        frame_type_next = cfg_we ? cfg_wdata : frame_type_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        target_next     = target_reg;
        asm_next        = asm_reg;
        phase_next      = phase_reg;
        grp_next        = grp_reg;
        stored_next     = stored_reg;
        tok_next        = tok_reg;
        ram_we          = 1'b0;
        if (cmd.take)
        begin
            priority if (pos_reg == 9'd0)
            begin
                pos_next = 9'(restart_pos);
            end
            else if (pos_reg == 9'd1)
            begin
                pos_next = (in_byte == CH_A) ? 9'd2 : 9'(restart_pos);
            end
            else if (pos_reg == 9'd2)
            begin
                pos_next = (in_byte == CH_UPPER_M) ? POS_LENGTH : 9'(restart_pos);
            end
            else if (fail)
            begin
                pos_next = 9'(restart_pos);
            end
            else
            begin
                len_next    = len_eff;
                tok_next    = tok_new;
                target_next = target_new;
                grp_next    = grp_eff;
                stored_next = stored_eff;
                asm_next    = asm_eff;
                phase_next  = phase_eff;
                if (pos_reg >= PAYLOAD_START)
                begin
                    unique case (phase_eff)
                        PH_HIGH: phase_next = PH_MID;
                        PH_MID:  phase_next = PH_LOW;
                        default: phase_next = PH_HIGH;
                    endcase
                    if (grp_eff < target_eff)
                    begin
                        unique case (phase_eff)
                            PH_HIGH: asm_next = {in_byte, 8'h00};
                            PH_MID:  asm_next = {asm_eff[15:8], in_byte};
                            default:
                            begin
                                ram_we      = 1'b1;
                                grp_next    = grp_eff + 1'b1;
                                stored_next = grp_eff + 1'b1;
                            end
                        endcase
                    end
                end
                pos_next = done ? 9'd0 : pos_reg + 9'd1;
            end
        end
    end

    assign ram_waddr = grp_reg[AW-1:0];
    assign ram_wdata = {asm_reg, in_byte};

    // Emission path
    assign idx_inc   = idx_reg + 1'b1;
    assign ram_re    = cmd.rd_first | cmd.rd_next;
    assign ram_raddr = cmd.rd_first ? '0 : idx_inc[AW-1:0];

    always_comb
    begin
        stat.frame_done = done;
        stat.empty      = (stored_reg == '0);
        stat.rd_last    = (idx_inc == stored_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg & out_stall;
        first_next     = first_reg;
        second_next    = second_reg;
        pv_next        = pv_reg;
        last_next      = last_reg;
        if (cmd.rd_first)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_inc;
        end
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            if (stat.empty)
            begin
                first_next  = 12'h000;
                second_next = 12'h000;
                pv_next     = 1'b0;
                last_next   = 1'b1;
            end
            else
            begin
                first_next  = {ram_rdata[23:16], ram_rdata[15:12]};
                second_next = {ram_rdata[11:8], ram_rdata[7:0]};
                pv_next     = 1'b1;
                last_next   = stat.rd_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_type_reg <= FRAME_TYPE_RESET;
            pos_reg        <= 9'd0;
            len_reg        <= 8'd0;
            target_reg     <= '0;
            asm_reg        <= 16'h0000;
            phase_reg      <= PH_HIGH;
            grp_reg        <= '0;
            stored_reg     <= '0;
            tok_reg        <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_type_reg <= frame_type_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            target_reg     <= target_next;
            asm_reg        <= asm_next;
            phase_reg      <= phase_next;
            grp_reg        <= grp_next;
            stored_reg     <= stored_next;
            tok_reg        <= tok_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        pv_reg     <= pv_next;
        last_reg   <= last_next;
    end

    efp_ram #(
        .WIDTH (24),
        .DEPTH (MAX_PAIRS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign first_sample  = first_reg;
    assign second_sample = second_reg;
    assign pair_valid    = pv_reg;
    assign frame_last    = last_reg;

endmodule

// ===== hw/rtl/efp_ctrl.sv =====
`timescale 1ns / 1ps

module efp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  efp_pkg::efp_stat_t stat,
    output efp_pkg::efp_cmd_t  cmd
);

    import efp_pkg::*;

    efp_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (in_valid && stat.frame_done)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = (stat.empty || stat.rd_last) ? ST_RECV : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != ST_RECV);
        cmd.take     = (state_reg == ST_RECV) && in_valid;
        cmd.rd_first = (state_reg == ST_START);
        cmd.rd_next  = (state_reg == ST_READ);
        cmd.load     = (state_reg == ST_LOAD) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/ecg_frame_parser_12bit_unpack.sv =====
// Frame parser with 12-bit sample unpacking.
// Input channel: one byte of the serial stream per word (in_valid, in_stall, in_byte).
// The parser hunts for 'M','A','M', checks the frame type at offset 5 against the
// register written through cfg_we / cfg_wdata, reads the sample count at offset 7
// and the trailer 'm' at offset L+5, and stores each three payload bytes as a pair.
// While receiving, one byte is taken every cycle; in_stall stays low.
// When the byte that completes a frame is taken, in_stall rises and the stored pairs
// are read out of the pair RAM one word at a time: a registered RAM read, then the
// output load, before the next word is read.
// An empty frame gives one word with pair_valid low and frame_last high.
// Output channel: out_valid, out_stall, first_sample, second_sample, pair_valid,
// frame_last. A stalled word holds; readout waits until the output register frees.
// Bytes are taken again as soon as the last word of a frame is loaded.
// Reset clears the hunt state, sets the frame type to 128 and empties the output.
`timescale 1ns / 1ps
`include "ecg_frame_parser_12bit_unpack_defines.svh"

module ecg_frame_parser_12bit_unpack #(
    parameter int MAX_PAIRS = efp_pkg::MAX_PAIRS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] first_sample,
    output logic [11:0] second_sample,
    output logic        pair_valid,
    output logic        frame_last
);

    import efp_pkg::*;

    efp_cmd_t  cmd;
    efp_stat_t stat;

    efp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    efp_datapath #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_byte       (in_byte),
        .cmd           (cmd),
        .stat          (stat),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .pair_valid    (pair_valid),
        .frame_last    (frame_last)
    );

    `EFP_ASSERT_NEXT(a_done_stalls, in_valid && !in_stall && stat.frame_done, in_stall)
    `EFP_ASSERT_NOW(a_empty_last, out_valid && !pair_valid, frame_last && (first_sample == 12'h000) && (second_sample == 12'h000))
    `EFP_ASSERT_NEXT(a_load_shows, cmd.load, out_valid)

endmodule
